FILE: sv/bws_pkg.sv
package bws_pkg;

   localparam int CS_W       = 14;
   localparam int SUM_W      = 20;
   localparam int POS_W      = 10;
   localparam int PCW        = 13;
   localparam int IMG_W      = 11;
   localparam int WIN_W      = 7;
   localparam int CSR_DATA_W = 11;
   localparam int MAX_HEIGHT = 1024;

   localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
   localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;
   localparam logic [WIN_W-1:0] WINDOW_WIDTH_RST = 7'd1;
   localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RST = 7'd1;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_WINDOW_WIDTH  = 2'd2,
      REG_WINDOW_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             last;
      logic [SUM_W-1:0] sum;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] x;
   } out_item_type;

endpackage

FILE: sv/bws_ram.sv
module bws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/box_window_sum_2d_unit.sv
// Box window sum over a raster grid of cell counts.
// req_*: one cell count per transfer, raster order (left to right, top to bottom).
// rsp_*: one transfer per window whose bottom-right cell has arrived, carrying
//   the window's top-left column and row and the sum of its counts; tlast marks
//   the final window of the frame. Cells where no window ends give no transfer.
// csr_*: image width/height and window width/height; any write restarts the
//   frame at the top-left cell. Write only while the block is idle.
// Throughput: one cell per cycle. Each cell makes one read-modify-write pass
//   through the column-sum memory (two read copies) and the row-history memory,
//   with forwarding between neighbouring cells on the same entry.
// Path: a result is registered in the second stage and then in the output
//   queue, from which it is offered on rsp.
// Stall: a two-entry output queue holds finished results; req_tready drops
//   only when that queue could otherwise overflow.
// Reset: registers return to their reset values and the frame starts at the
//   top-left cell. The memories need no clearing pass: every entry is written
//   within a frame before its read value is used.
module box_window_sum_2d_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_WIN    = 64,
   parameter int COUNT_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // cell_count
   input  logic [((COUNT_BITS + 7) / 8) * 8-1:0] req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // win_x [9:0], win_y [19:10], win_sum [39:20]
   output logic [39:0]                          rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  bws_pkg::csr_index_type               csr_addr,
   input  logic [bws_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import bws_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
   localparam int HW = SW + XW;
   localparam int EW = (COUNT_BITS > CS_W) ? COUNT_BITS : CS_W;

   // configuration
   logic [IMG_W-1:0] image_width_ff, image_height_ff;
   logic [WIN_W-1:0] window_width_ff, window_height_ff;
   logic [IMG_W-1:0] iw, ih;
   logic [WIN_W-1:0] ww, wh;

   // position
   logic [XW-1:0]    x_ff, x_in;
   logic [POS_W-1:0] y_ff, y_in;
   logic [SW-1:0]    slot_ff, slot_in;

   // second stage
   logic                  s1_valid_ff;
   logic [XW-1:0]         s1_x_ff;
   logic [HW-1:0]         s1_hidx_ff;
   logic [COUNT_BITS-1:0] s1_cell_ff;
   logic                  s1_first_row_ff, s1_sub_hist_ff, s1_sub_col_ff, s1_row_start_ff;
   logic                  s1_emit_ff, s1_last_ff;
   logic [POS_W-1:0]      s1_win_x_ff, s1_win_y_ff;
   logic                  fwd_c0_ff, fwd_c1_ff, fwd_h_ff;
   logic [CS_W-1:0]       fwd_cs_ff;
   logic [COUNT_BITS-1:0] fwd_cell_ff;
   logic [SUM_W-1:0]      running_sum_ff, running_sum_in;

   // output queue
   out_item_type q_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   q_count_ff;

   logic                  req_accept, rsp_pop, q_push;
   logic [COUNT_BITS-1:0] cell_count;
   logic [PCW-1:0]        xp1, yp1;
   logic                  x_wrap, y_wrap;
   logic [XW-1:0]         rd1_addr;
   logic [HW-1:0]         hidx;
   logic [CS_W-1:0]       c0_rd, c1_rd, colsum, col_old, cs_in;
   logic [COUNT_BITS-1:0] h_rd, hist;
   logic [EW-1:0]         cs_ext;
   logic [2:0]            room_need;

   always_comb begin
      iw = image_width_ff;
      if (image_width_ff == '0) begin
         iw = IMG_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         iw = IMG_W'(MAX_WIDTH);
      end
      ih = image_height_ff;
      if (image_height_ff == '0) begin
         ih = IMG_W'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         ih = IMG_W'(MAX_HEIGHT);
      end
      ww = window_width_ff;
      if (window_width_ff == '0) begin
         ww = WIN_W'(1);
      end else if (32'(window_width_ff) > MAX_WIN) begin
         ww = WIN_W'(MAX_WIN);
      end
      wh = window_height_ff;
      if (window_height_ff == '0) begin
         wh = WIN_W'(1);
      end else if (32'(window_height_ff) > MAX_WIN) begin
         wh = WIN_W'(MAX_WIN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= IMAGE_WIDTH_RST;
         image_height_ff  <= IMAGE_HEIGHT_RST;
         window_width_ff  <= WINDOW_WIDTH_RST;
         window_height_ff <= WINDOW_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[IMG_W-1:0];
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata[IMG_W-1:0];
            REG_WINDOW_WIDTH:  window_width_ff  <= csr_wdata[WIN_W-1:0];
            REG_WINDOW_HEIGHT: window_height_ff <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // first stage: position, addresses, forwarding decisions
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign cell_count = req_tdata[COUNT_BITS-1:0];
   assign xp1        = PCW'(x_ff) + PCW'(1);
   assign yp1        = PCW'(y_ff) + PCW'(1);
   assign x_wrap     = xp1 >= PCW'(iw);
   assign y_wrap     = yp1 >= PCW'(ih);
   assign rd1_addr   = XW'(PCW'(x_ff) - PCW'(ww));
   assign hidx       = {slot_ff, x_ff};

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      slot_in = slot_ff;
      if (req_accept) begin
         if (x_wrap) begin
            x_in = '0;
            if (y_wrap) begin
               y_in    = '0;
               slot_in = '0;
            end else begin
               y_in = yp1[POS_W-1:0];
               if (PCW'(slot_ff) + PCW'(1) >= PCW'(wh)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + SW'(1);
               end
            end
         end else begin
            x_in = xp1[XW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         x_ff    <= '0;
         y_ff    <= '0;
         slot_ff <= '0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_x_ff         <= x_ff;
         s1_hidx_ff      <= hidx;
         s1_cell_ff      <= cell_count;
         s1_first_row_ff <= (y_ff == '0);
         s1_sub_hist_ff  <= PCW'(y_ff) >= PCW'(wh);
         s1_sub_col_ff   <= PCW'(x_ff) >= PCW'(ww);
         s1_row_start_ff <= (x_ff == '0);
         s1_emit_ff      <= (xp1 >= PCW'(ww)) && (yp1 >= PCW'(wh));
         s1_last_ff      <= (xp1 == PCW'(iw)) && (yp1 == PCW'(ih));
         s1_win_x_ff     <= POS_W'(xp1 - PCW'(ww));
         s1_win_y_ff     <= POS_W'(yp1 - PCW'(wh));
         fwd_c0_ff       <= s1_valid_ff && (s1_x_ff == x_ff);
         fwd_c1_ff       <= s1_valid_ff && (s1_x_ff == rd1_addr);
         fwd_h_ff        <= s1_valid_ff && (s1_hidx_ff == hidx);
         fwd_cs_ff       <= cs_in;
         fwd_cell_ff     <= s1_cell_ff;
      end
   end

   bws_ram #(.WIDTH(CS_W), .DEPTH(2 ** XW)) u_colsum_a (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (cs_in),
      .rd_addr (x_ff),
      .rd_data (c0_rd)
   );

   bws_ram #(.WIDTH(CS_W), .DEPTH(2 ** XW)) u_colsum_b (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (cs_in),
      .rd_addr (rd1_addr),
      .rd_data (c1_rd)
   );

   bws_ram #(.WIDTH(COUNT_BITS), .DEPTH(2 ** HW)) u_history (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_hidx_ff),
      .wr_data (s1_cell_ff),
      .rd_addr (hidx),
      .rd_data (h_rd)
   );

   // second stage: column sum and row sum update
   assign colsum  = fwd_c0_ff ? fwd_cs_ff : c0_rd;
   assign col_old = fwd_c1_ff ? fwd_cs_ff : c1_rd;
   assign hist    = fwd_h_ff ? fwd_cell_ff : h_rd;

   always_comb begin
      if (s1_first_row_ff) begin
         cs_ext = EW'(s1_cell_ff);
      end else if (s1_sub_hist_ff) begin
         cs_ext = EW'(colsum) + EW'(s1_cell_ff) - EW'(hist);
      end else begin
         cs_ext = EW'(colsum) + EW'(s1_cell_ff);
      end
      cs_in = cs_ext[CS_W-1:0];

      running_sum_in = s1_row_start_ff ? '0 : running_sum_ff;
      running_sum_in = running_sum_in + SUM_W'(cs_in);
      if (s1_sub_col_ff) begin
         running_sum_in = running_sum_in - SUM_W'(col_old);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         running_sum_ff <= '0;
      end else if (s1_valid_ff) begin
         running_sum_ff <= running_sum_in;
      end
   end

   // output queue
   assign q_push    = s1_valid_ff && s1_emit_ff;
   assign room_need = 3'(q_count_ff) + 3'(s1_valid_ff) - 3'(rsp_pop);
   assign req_tready = room_need < 3'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         q_count_ff <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         q_count_ff <= q_count_ff + 2'(q_push) - 2'(rsp_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wr_ptr_ff] <= '{last: s1_last_ff, sum: running_sum_in,
                              y: s1_win_y_ff, x: s1_win_x_ff};
      end
   end

   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata  = {q_ff[rd_ptr_ff].sum, q_ff[rd_ptr_ff].y, q_ff[rd_ptr_ff].x};
   assign rsp_tlast  = q_ff[rd_ptr_ff].last;

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !rsp_pop) |-> (q_count_ff != 2'd2))
      else $error("output queue overflow");

   a_accept_reaches_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted cell lost before second stage");

   a_col_in_image: assert property (@(posedge clock) disable iff (reset)
      PCW'(x_ff) < PCW'(iw))
      else $error("column position beyond image width");

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      PCW'(slot_ff) < PCW'(wh))
      else $error("history slot beyond window height");

endmodule

FILE: sim/box_sum_checker.sv
module box_sum_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     req_tdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [39:0]                    rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  bws_pkg::csr_index_type         csr_addr,
   input  logic [bws_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             windows_pending,
   output int                             mismatch_count,
   output int                             windows_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import bws_pkg::*;

   localparam int GRID_COLS = 1024;
   localparam int WIN_MAX   = 64;

   logic [IMG_W-1:0] img_cols;
   logic [IMG_W-1:0] img_rows;
   logic [WIN_W-1:0] win_cols;
   logic [WIN_W-1:0] win_rows;
   logic [POS_W-1:0] next_col;
   logic [POS_W-1:0] next_row;
   logic [CS_W-1:0]  column_total [GRID_COLS];
   logic [7:0]       recent_rows [WIN_MAX*GRID_COLS];
   logic [SUM_W-1:0] row_window_sum;
   out_item_type     expected_windows [$];
   int               fail_tally;
   int               checked_tally;

   function automatic int clamp_size(int value, int upper);
      if (value < 1) return 1;
      if (value > upper) return upper;
      return value;
   endfunction

   task automatic accumulate_count(input logic [7:0] count_in);
      int              iw;
      int              ih;
      int              ww;
      int              wh;
      int              x;
      int              y;
      int              slot_idx;
      logic [CS_W-1:0] col_sum;
      out_item_type    win;
      iw = clamp_size(int'(img_cols), GRID_COLS);
      ih = clamp_size(int'(img_rows), MAX_HEIGHT);
      ww = clamp_size(int'(win_cols), WIN_MAX);
      wh = clamp_size(int'(win_rows), WIN_MAX);
      x = int'(next_col);
      y = int'(next_row);
      if (x >= iw) x = 0;
      if (y >= ih) y = 0;
      slot_idx = (y % wh) * GRID_COLS + x;

      if (y == 0) begin
         col_sum = CS_W'(count_in);
      end else begin
         col_sum = column_total[10'(x)] + CS_W'(count_in);
         if (y >= wh) col_sum = col_sum - CS_W'(recent_rows[16'(slot_idx)]);
      end
      column_total[10'(x)] = col_sum;
      recent_rows[16'(slot_idx)] = count_in;

      if (x == 0) row_window_sum = '0;
      row_window_sum = row_window_sum + SUM_W'(col_sum);
      if (x >= ww) row_window_sum = row_window_sum - SUM_W'(column_total[10'(x - ww)]);

      if (x + 1 >= ww && y + 1 >= wh) begin
         win.x    = POS_W'(x + 1 - ww);
         win.y    = POS_W'(y + 1 - wh);
         win.sum  = row_window_sum;
         win.last = (x == iw - 1 && y == ih - 1);
         expected_windows.push_back(win);
      end

      x++;
      if (x >= iw) begin
         x = 0;
         y++;
         if (y >= ih) y = 0;
      end
      next_col = POS_W'(x);
      next_row = POS_W'(y);
   endtask

   always @(posedge clock) begin
      out_item_type want;
      if (reset) begin
         img_cols = IMAGE_WIDTH_RST;
         img_rows = IMAGE_HEIGHT_RST;
         win_cols = WINDOW_WIDTH_RST;
         win_rows = WINDOW_HEIGHT_RST;
         next_col = '0;
         next_row = '0;
         row_window_sum = '0;
         foreach (column_total[i]) column_total[i] = '0;
         foreach (recent_rows[i]) recent_rows[i] = '0;
         expected_windows.delete();
         fail_tally = 0;
         checked_tally = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_IMAGE_WIDTH:   img_cols = csr_wdata;
               REG_IMAGE_HEIGHT:  img_rows = csr_wdata;
               REG_WINDOW_WIDTH:  win_cols = csr_wdata[WIN_W-1:0];
               REG_WINDOW_HEIGHT: win_rows = csr_wdata[WIN_W-1:0];
               default: ;
            endcase
            // restart the frame
            next_col = '0;
            next_row = '0;
            row_window_sum = '0;
         end
         if (req_tvalid && req_tready) accumulate_count(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_windows.size() == 0) begin
               $error("rsp transfer with no window outstanding: win_x %0d win_y %0d win_sum %0d",
                      rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[39:20]);
               fail_tally++;
            end else begin
               want = expected_windows.pop_front();
               checked_tally++;
               if (rsp_tdata[9:0] !== want.x) begin
                  $error("win_x: expected %0d, got %0d", want.x, rsp_tdata[9:0]);
                  fail_tally++;
               end
               if (rsp_tdata[19:10] !== want.y) begin
                  $error("win_y: expected %0d, got %0d", want.y, rsp_tdata[19:10]);
                  fail_tally++;
               end
               if (rsp_tdata[39:20] !== want.sum) begin
                  $error("win_sum: expected %0d, got %0d", want.sum, rsp_tdata[39:20]);
                  fail_tally++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_window: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_tally++;
               end
            end
         end
      end
      windows_pending <= expected_windows.size();
      mismatch_count  <= fail_tally;
      windows_checked <= checked_tally;
   end

endmodule

FILE: sim/tb_box_window_sum_2d_unit.sv
module tb_box_window_sum_2d_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bws_pkg::*;

   typedef enum logic {FILL_RANDOM, FILL_FULL} fill_kind_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   csr_index_type         csr_addr   = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int windows_pending;
   int mismatch_count;
   int windows_checked;

   int send_gap_pct   = 30;
   int sink_stall_pct = 30;
   bit quiet          = 1'b0;
   int stall_left     = 0;
   int cells_sent     = 0;
   int settings_used  = 0;
   int stuck_count    = 0;
   int failures;

   logic [7:0] edge_counts [14] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h0F,
                                    8'hF0, 8'h80, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};

   box_window_sum_2d_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   box_sum_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .windows_pending (windows_pending),
      .mismatch_count  (mismatch_count),
      .windows_checked (windows_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(99) < sink_stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(12, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_count(input logic [7:0] value);
      if (!quiet && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
   endtask

   task automatic wait_windows_done();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (windows_pending != 0 && waited < 3000);
      if (windows_pending != 0) begin
         $error("%0d windows still outstanding after %0d cycles", windows_pending, waited);
         stuck_count++;
      end
   endtask

   task automatic stream_counts(input int n, input fill_kind_type fill, input bit hold_midway);
      for (int i = 0; i < n; i++) begin
         if (hold_midway && i == n / 2) wait_windows_done();
         send_count(fill == FILL_FULL ? 8'hFF : 8'($urandom_range(255)));
      end
   endtask

   task automatic settle();
      wait_windows_done();
      // let cells that make no window leave the pipeline
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] iw, input logic [CSR_DATA_W-1:0] ih,
                               input logic [CSR_DATA_W-1:0] ww, input logic [CSR_DATA_W-1:0] wh);
      settle();
      write_reg(REG_IMAGE_WIDTH, iw);
      write_reg(REG_IMAGE_HEIGHT, ih);
      write_reg(REG_WINDOW_WIDTH, ww);
      write_reg(REG_WINDOW_HEIGHT, wh);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      #20ms;
      $display("Timeout: stimulus or results stopped moving");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: every cell closes a one-by-one window
      foreach (edge_counts[i]) send_count(edge_counts[i]);
      stream_counts(11, FILL_RANDOM, 1'b0);

      set_geometry(7, 5, 3, 2);
      stream_counts(70, FILL_RANDOM, 1'b1);
      set_geometry(1, 1, 1, 1);
      stream_counts(30, FILL_RANDOM, 1'b0);
      set_geometry(5, 4, 6, 2);
      stream_counts(40, FILL_RANDOM, 1'b0);
      set_geometry(5, 4, 3, 5);
      stream_counts(40, FILL_RANDOM, 1'b0);
      set_geometry(9, 3, 0, 0);
      stream_counts(40, FILL_RANDOM, 1'b0);

      send_gap_pct   = 5;
      sink_stall_pct = 5;
      set_geometry(0, 1500, 1, 100);
      stream_counts(150, FILL_RANDOM, 1'b0);
      set_geometry(2047, 0, 127, 1);
      stream_counts(150, FILL_RANDOM, 1'b0);
      set_geometry(6, 64, 6, 11'h7FF);
      stream_counts(384, FILL_FULL, 1'b0);

      send_gap_pct   = 25;
      sink_stall_pct = 25;
      set_geometry(12, 9, 4, 3);
      stream_counts(50, FILL_RANDOM, 1'b0);
      settle();
      write_reg(REG_WINDOW_HEIGHT, 2);
      csr_we <= 1'b0;
      settings_used++;
      stream_counts(60, FILL_RANDOM, 1'b0);

      for (int p = 0; p < 8; p++) begin
         send_gap_pct   = $urandom_range(40, 0);
         sink_stall_pct = $urandom_range(40, 0);
         if (p == 7) quiet = 1'b1;
         set_geometry(CSR_DATA_W'($urandom_range(24, 1)), CSR_DATA_W'($urandom_range(12, 1)),
                      CSR_DATA_W'($urandom_range(8, 1)), CSR_DATA_W'($urandom_range(6, 1)));
         stream_counts($urandom_range(40, 20), FILL_RANDOM, p == 3);
      end

      settle();
      $display("Checked %0d windows from %0d cell transfers over %0d geometry settings,",
               windows_checked, cells_sent, settings_used);
      $display("with clamped sizes, frame wrap, windows that never fit and full-scale columns.");
      failures = mismatch_count + stuck_count;
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/bws_pkg.sv
sv/bws_ram.sv
sv/box_window_sum_2d_unit.sv
sim/box_sum_checker.sv
sim/tb_box_window_sum_2d_unit.sv
